>>> rtl/core/lcdseq_pkg.sv
`default_nettype none

package lcdseq_pkg;

    localparam int NUM_COLUMNS = 16;
    localparam int NUM_ROWS    = 2;

    localparam int STEP_W = 6;

    // Microcode layout: init program first, shared byte routine after it
    localparam logic [STEP_W-1:0] INIT_ENTRY = 6'd0;
    localparam logic [STEP_W-1:0] BYTE_ENTRY = 6'd43;
    localparam logic [STEP_W-1:0] STEP_LAST  = 6'd48;

    localparam logic [15:0] HOLD_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        REQ_INIT   = 3'd0,
        REQ_PRINT  = 3'd1,
        REQ_RAW    = 3'd2,
        REQ_CURSOR = 3'd3,
        REQ_CLEAR  = 3'd4
    } req_kind_t;

    typedef enum logic [1:0] {
        NIB_CONST = 2'd0,
        NIB_HI    = 2'd1,
        NIB_LO    = 2'd2
    } nib_src_t;

    typedef enum logic {
        HOLD_CONST = 1'b0,
        HOLD_REQ   = 1'b1
    } hold_src_t;

    typedef struct packed {
        logic        en;
        logic        rs_req;
        nib_src_t    nib_src;
        logic [3:0]  nib_const;
        hold_src_t   hold_src;
        logic [15:0] hold_const;
        logic        fin;
    } ucode_t;

    typedef struct packed {
        logic        rs_pin;
        logic        enable_pin;
        logic [3:0]  nibble;
        logic [15:0] hold_us;
        logic        last;
    } phase_t;

    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_NONE  = 8'h00;
    localparam logic [7:0] CMD_DDRAM = 8'h80;

    localparam logic [15:0] HOLD_PRINT = 16'd51;
    localparam logic [15:0] HOLD_CMD   = 16'd41;
    localparam logic [15:0] HOLD_CLEAR = 16'd1641;

endpackage

`default_nettype wire

>>> rtl/core/lcdseq_if.sv
`default_nettype none

interface lcdseq_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [7:0]  data_byte;
    logic        rs_flag;
    logic [15:0] delay_us;
    logic [4:0]  column;
    logic [1:0]  row;

    modport source (output valid, req_type, data_byte, rs_flag, delay_us, column, row,
                    input ready);
    modport sink   (input valid, req_type, data_byte, rs_flag, delay_us, column, row,
                    output ready);
endinterface

interface lcdseq_phase_if;
    logic        valid;
    logic        ready;
    logic        rs_pin;
    logic        enable_pin;
    logic [3:0]  nibble;
    logic [15:0] hold_us;
    logic        last;

    modport source (output valid, rs_pin, enable_pin, nibble, hold_us, last,
                    input ready);
    modport sink   (input valid, rs_pin, enable_pin, nibble, hold_us, last,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/lcdseq_ucode.sv
`default_nettype none

module lcdseq_ucode (
    input  wire logic [lcdseq_pkg::STEP_W-1:0] step,
    output lcdseq_pkg::ucode_t                 word
);
    import lcdseq_pkg::*;

    // constant init phase: RS low, fixed nibble and hold
    function automatic ucode_t ph(input logic en, input logic [3:0] nib,
                                  input logic [15:0] hold, input logic fin);
        ucode_t w;
        w.en         = en;
        w.rs_req     = 1'b0;
        w.nib_src    = NIB_CONST;
        w.nib_const  = nib;
        w.hold_src   = HOLD_CONST;
        w.hold_const = hold;
        w.fin        = fin;
        return w;
    endfunction

    // byte routine phase driven by the latched request
    function automatic ucode_t bp(input logic en, input logic rs, input nib_src_t src,
                                  input hold_src_t hs, input logic [15:0] hold,
                                  input logic fin);
        ucode_t w;
        w.en         = en;
        w.rs_req     = rs;
        w.nib_src    = src;
        w.nib_const  = 4'h0;
        w.hold_src   = hs;
        w.hold_const = hold;
        w.fin        = fin;
        return w;
    endfunction

    always_comb
    begin
        case (step)
            // power-up wait
            6'd0:  word = ph(1'b0, 4'h0, 16'd15000, 1'b0);
            // function set nibbles
            6'd1:  word = ph(1'b1, 4'h3, 16'd1, 1'b0);
            6'd2:  word = ph(1'b0, 4'h3, 16'd1, 1'b0);
            6'd3:  word = ph(1'b0, 4'h3, 16'd4201, 1'b0);
            6'd4:  word = ph(1'b1, 4'h3, 16'd1, 1'b0);
            6'd5:  word = ph(1'b0, 4'h3, 16'd1, 1'b0);
            6'd6:  word = ph(1'b0, 4'h3, 16'd151, 1'b0);
            // 0x32
            6'd7:  word = ph(1'b1, 4'h3, 16'd1, 1'b0);
            6'd8:  word = ph(1'b0, 4'h3, 16'd1, 1'b0);
            6'd9:  word = ph(1'b0, 4'h3, 16'd2, 1'b0);
            6'd10: word = ph(1'b1, 4'h2, 16'd1, 1'b0);
            6'd11: word = ph(1'b0, 4'h2, 16'd1, 1'b0);
            6'd12: word = ph(1'b0, 4'h2, 16'd41, 1'b0);
            // 0x28
            6'd13: word = ph(1'b1, 4'h2, 16'd1, 1'b0);
            6'd14: word = ph(1'b0, 4'h2, 16'd1, 1'b0);
            6'd15: word = ph(1'b0, 4'h2, 16'd2, 1'b0);
            6'd16: word = ph(1'b1, 4'h8, 16'd1, 1'b0);
            6'd17: word = ph(1'b0, 4'h8, 16'd1, 1'b0);
            6'd18: word = ph(1'b0, 4'h8, 16'd41, 1'b0);
            // 0x08
            6'd19: word = ph(1'b1, 4'h0, 16'd1, 1'b0);
            6'd20: word = ph(1'b0, 4'h0, 16'd1, 1'b0);
            6'd21: word = ph(1'b0, 4'h0, 16'd2, 1'b0);
            6'd22: word = ph(1'b1, 4'h8, 16'd1, 1'b0);
            6'd23: word = ph(1'b0, 4'h8, 16'd1, 1'b0);
            6'd24: word = ph(1'b0, 4'h8, 16'd41, 1'b0);
            // 0x01, long clear delay
            6'd25: word = ph(1'b1, 4'h0, 16'd1, 1'b0);
            6'd26: word = ph(1'b0, 4'h0, 16'd1, 1'b0);
            6'd27: word = ph(1'b0, 4'h0, 16'd2, 1'b0);
            6'd28: word = ph(1'b1, 4'h1, 16'd1, 1'b0);
            6'd29: word = ph(1'b0, 4'h1, 16'd1, 1'b0);
            6'd30: word = ph(1'b0, 4'h1, 16'd1641, 1'b0);
            // 0x06
            6'd31: word = ph(1'b1, 4'h0, 16'd1, 1'b0);
            6'd32: word = ph(1'b0, 4'h0, 16'd1, 1'b0);
            6'd33: word = ph(1'b0, 4'h0, 16'd2, 1'b0);
            6'd34: word = ph(1'b1, 4'h6, 16'd1, 1'b0);
            6'd35: word = ph(1'b0, 4'h6, 16'd1, 1'b0);
            6'd36: word = ph(1'b0, 4'h6, 16'd41, 1'b0);
            // 0x0F, end of init
            6'd37: word = ph(1'b1, 4'h0, 16'd1, 1'b0);
            6'd38: word = ph(1'b0, 4'h0, 16'd1, 1'b0);
            6'd39: word = ph(1'b0, 4'h0, 16'd2, 1'b0);
            6'd40: word = ph(1'b1, 4'hF, 16'd1, 1'b0);
            6'd41: word = ph(1'b0, 4'hF, 16'd1, 1'b0);
            6'd42: word = ph(1'b0, 4'hF, 16'd41, 1'b1);
            // shared byte routine
            6'd43: word = bp(1'b1, 1'b1, NIB_HI, HOLD_CONST, 16'd1, 1'b0);
            6'd44: word = bp(1'b0, 1'b1, NIB_HI, HOLD_CONST, 16'd1, 1'b0);
            6'd45: word = bp(1'b0, 1'b0, NIB_HI, HOLD_CONST, 16'd2, 1'b0);
            6'd46: word = bp(1'b1, 1'b1, NIB_LO, HOLD_CONST, 16'd1, 1'b0);
            6'd47: word = bp(1'b0, 1'b1, NIB_LO, HOLD_CONST, 16'd1, 1'b0);
            6'd48: word = bp(1'b0, 1'b0, NIB_LO, HOLD_REQ, 16'd0, 1'b1);
            default: word = ph(1'b0, 4'h0, 16'd0, 1'b1);
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/lcdseq_phase_dp.sv
`default_nettype none

module lcdseq_phase_dp (
    input  wire lcdseq_pkg::ucode_t word,
    input  wire logic [7:0]         byte_val,
    input  wire logic               rs_val,
    input  wire logic [15:0]        hold_val,
    output lcdseq_pkg::phase_t      phase
);
    import lcdseq_pkg::*;

    always_comb
    begin
        phase.rs_pin     = word.rs_req & rs_val;
        phase.enable_pin = word.en;
        case (word.nib_src)
            NIB_HI:  phase.nibble = byte_val[7:4];
            NIB_LO:  phase.nibble = byte_val[3:0];
            default: phase.nibble = word.nib_const;
        endcase
        phase.hold_us = (word.hold_src == HOLD_REQ) ? hold_val : word.hold_const;
        phase.last    = word.fin;
    end

endmodule

`default_nettype wire

>>> rtl/core/char_lcd_nibble_sequencer.sv
`default_nettype none

// Channel   Dir  Transfer carries
// req       in   req_type, data_byte, rs_flag, delay_us, column, row
// phase     out  rs_pin, enable_pin, nibble, hold_us, last
//
// One phase leaves per cycle while the output register is free; a byte request
// takes 6 phases, init 43, set by the step counter walking the control ROM.
// A request is taken only when the previous run has issued its last phase; an
// unknown request type is taken and produces nothing.
// A stall on phase holds the step counter; the output register parts the sides.
// rst_n clears the busy flag and output valid asynchronously.
module char_lcd_nibble_sequencer (
    input  wire logic      clk,
    input  wire logic      rst_n,
    lcdseq_req_if.sink     req,
    lcdseq_phase_if.source phase
);
    import lcdseq_pkg::*;

    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [7:0]          byte_reg, byte_next;
    logic                rs_reg, rs_next;
    logic [15:0]         hold_reg, hold_next;
    logic                out_valid_reg, out_valid_next;
    phase_t              out_reg, out_next;

    ucode_t              word;
    phase_t              cur_phase;
    logic                accept;
    logic                advance;
    logic                cur_ok;
    logic [7:0]          cur_cmd;
    logic [15:0]         raw_hold;

    lcdseq_ucode u_ucode (
        .step (step_reg),
        .word (word)
    );

    lcdseq_phase_dp u_dp (
        .word     (word),
        .byte_val (byte_reg),
        .rs_val   (rs_reg),
        .hold_val (hold_reg),
        .phase    (cur_phase)
    );

    assign req.ready = !busy_reg;
    assign accept    = req.valid && !busy_reg;
    // issue the next phase when the output register is free or being drained
    assign advance   = busy_reg && (!out_valid_reg || phase.ready);

    // cursor command: DDRAM address of row/column, or no-op when out of range
    assign cur_ok = (req.row >= 2'd1) && (32'(req.row) <= NUM_ROWS) &&
                    (req.column >= 5'd1) && (32'(req.column) <= NUM_COLUMNS);
    assign cur_cmd = cur_ok ?
        (CMD_DDRAM | {1'b0, (req.row == 2'd2), 6'({1'b0, req.column - 5'd1})}) : CMD_NONE;

    // saturate 1 + delay at the hold field's range
    assign raw_hold = (req.delay_us == HOLD_MAX) ? HOLD_MAX : req.delay_us + 16'd1;

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        byte_next      = byte_reg;
        rs_next        = rs_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (advance)
        begin
            out_next       = cur_phase;
            out_valid_next = 1'b1;
            step_next      = step_reg + 6'd1;
            if (word.fin)
            begin
                busy_next = 1'b0;
            end
        end
        else if (phase.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            case (req.req_type)
                REQ_INIT:
                begin
                    step_next = INIT_ENTRY;
                    busy_next = 1'b1;
                end
                REQ_PRINT:
                begin
                    step_next = BYTE_ENTRY;
                    byte_next = req.data_byte;
                    rs_next   = 1'b1;
                    hold_next = HOLD_PRINT;
                    busy_next = 1'b1;
                end
                REQ_RAW:
                begin
                    step_next = BYTE_ENTRY;
                    byte_next = req.data_byte;
                    rs_next   = req.rs_flag;
                    hold_next = raw_hold;
                    busy_next = 1'b1;
                end
                REQ_CURSOR:
                begin
                    step_next = BYTE_ENTRY;
                    byte_next = cur_cmd;
                    rs_next   = 1'b0;
                    hold_next = HOLD_CMD;
                    busy_next = 1'b1;
                end
                REQ_CLEAR:
                begin
                    step_next = BYTE_ENTRY;
                    byte_next = CMD_CLEAR;
                    rs_next   = 1'b0;
                    hold_next = HOLD_CLEAR;
                    busy_next = 1'b1;
                end
                default:
                begin
                    // drop unknown requests
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= INIT_ENTRY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        rs_reg   <= rs_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign phase.valid      = out_valid_reg;
    assign phase.rs_pin     = out_reg.rs_pin;
    assign phase.enable_pin = out_reg.enable_pin;
    assign phase.nibble     = out_reg.nibble;
    assign phase.hold_us    = out_reg.hold_us;
    assign phase.last       = out_reg.last;

    // a known request starts a run
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.req_type <= REQ_CLEAR) |=> busy_reg)
        else $error("known request did not start a run");

    // stalled output holds the step counter
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && out_valid_reg && !phase.ready |=> $stable(step_reg))
        else $error("step advanced under output stall");

    // the step counter stays inside the control program while running
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg <= STEP_LAST)
        else $error("step counter left the control program");

    // a run issues a phase whenever the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !out_valid_reg |=> out_valid_reg)
        else $error("free output register not filled");

endmodule

`default_nettype wire
